// ===== rtl/psuc_pkg.sv =====
// Shared types, constants and a helper of the PCM sample unpacker and converter.
package psuc_pkg;

  localparam int unsigned MAX_BYTES_PER_SAMPLE = 16;
  localparam int unsigned QUEUE_DEPTH          = 2;
  localparam int unsigned CFG_ADDR_W           = 4;
  localparam int unsigned CFG_DATA_W           = 32;

  localparam logic [4:0]  BPS_RESET   = 5'd2;
  localparam logic [6:0]  VBITS_RESET = 7'd16;
  localparam logic [15:0] CHANS_RESET = 16'd1;

  typedef enum logic [1:0] {
    REG_BYTES_PER_SAMPLE = 2'd0,
    REG_VALID_BITS       = 2'd1,
    REG_CHANNEL_COUNT    = 2'd2,
    REG_OUTPUT_FORMAT    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S32 = 2'd2,
    FMT_RSV = 2'd3
  } fmt_t;

  typedef struct packed {
    logic [4:0]  bytes_per_sample;
    logic [6:0]  valid_bits;
    logic [15:0] channel_count;
    fmt_t        output_format;
  } cfg_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        rnd;
    logic [15:0] chan;
    logic        last;
  } q_entry_t;

  // Container size clamped to the range from one byte to the supported maximum.
  function automatic logic [4:0] eff_bytes(input logic [4:0] bps, input logic [4:0] max_b);
    logic [4:0] n;
    n = bps;
    if (n == 5'd0) n = 5'd1;
    if (n > max_b) n = max_b;
    return n;
  endfunction

endpackage

// ===== rtl/psuc_in_if.sv =====
// Byte input channel: valid/ready handshake with the raw byte and chunk start flag.
interface psuc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;

  modport source (output valid, output data_byte, output chunk_start, input ready);
  modport sink   (input valid, input data_byte, input chunk_start, output ready);
endinterface

// ===== rtl/psuc_out_if.sv =====
// Sample output channel: valid/ready handshake with the converted sample and its tags.
interface psuc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic [15:0]        channel_index;
  logic               end_of_block;

  modport source (output valid, output sample_value, output channel_index,
                  output end_of_block, input ready);
  modport sink   (input valid, input sample_value, input channel_index,
                  input end_of_block, output ready);
endinterface

// ===== rtl/psuc_cfg.sv =====
// APB-style configuration register bank.
module psuc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psuc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [psuc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [psuc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output psuc_pkg::cfg_t                    cfg
);

  psuc_pkg::cfg_t   cfg_r;
  psuc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = psuc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes_per_sample <= psuc_pkg::BPS_RESET;
      cfg_r.valid_bits       <= psuc_pkg::VBITS_RESET;
      cfg_r.channel_count    <= psuc_pkg::CHANS_RESET;
      cfg_r.output_format    <= psuc_pkg::FMT_S16;
    end else if (wr_en) begin
      unique case (idx)
        psuc_pkg::REG_BYTES_PER_SAMPLE: cfg_r.bytes_per_sample <= pwdata[4:0];
        psuc_pkg::REG_VALID_BITS:       cfg_r.valid_bits       <= pwdata[6:0];
        psuc_pkg::REG_CHANNEL_COUNT:    cfg_r.channel_count    <= pwdata[15:0];
        psuc_pkg::REG_OUTPUT_FORMAT:
          cfg_r.output_format <= psuc_pkg::fmt_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      psuc_pkg::REG_BYTES_PER_SAMPLE: prdata = {27'd0, cfg_r.bytes_per_sample};
      psuc_pkg::REG_VALID_BITS:       prdata = {25'd0, cfg_r.valid_bits};
      psuc_pkg::REG_CHANNEL_COUNT:    prdata = {16'd0, cfg_r.channel_count};
      psuc_pkg::REG_OUTPUT_FORMAT:    prdata = {30'd0, cfg_r.output_format};
      default:                        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/psuc_front.sv =====
// Front end: accepts bytes, tracks byte and channel position and assembles samples.
module psuc_front #(
  parameter int unsigned MAX_BYTES = psuc_pkg::MAX_BYTES_PER_SAMPLE
) (
  input  logic               clk,
  input  logic               rst_n,
  psuc_in_if.sink            in_ch,
  input  psuc_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output psuc_pkg::q_entry_t q_data
);

  localparam int unsigned PW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [PW-1:0]      pos_r, pos_nxt, p_eff;
  logic [15:0]        ch_r, ch_nxt, ch_eff, nch;
  logic [63:0]        acc_r, acc_nxt, acc_base;
  logic               rnd_r, rnd_nxt;
  logic [4:0]         nb;
  logic signed [5:0]  lane;
  logic               done, last, accept;

  assign nb     = psuc_pkg::eff_bytes(cfg.bytes_per_sample, 5'(MAX_BYTES));
  assign nch    = (cfg.channel_count == 16'd0) ? 16'd1 : cfg.channel_count;
  assign p_eff  = in_ch.chunk_start ? '0 : pos_r;
  assign ch_eff = in_ch.chunk_start ? 16'd0 : ch_r;
  assign lane   = $signed(6'(p_eff)) + 6'sd8 - $signed({1'b0, nb});

  always_comb begin
    acc_base = (p_eff == '0) ? 64'd0 : acc_r;
    acc_nxt  = acc_base;
    for (int i = 0; i < 8; i++) begin
      if (lane == 6'(i)) acc_nxt[8*i +: 8] = acc_base[8*i +: 8] | in_ch.data_byte;
    end
    if (lane == -6'sd1) rnd_nxt = in_ch.data_byte[7];
    else                rnd_nxt = (p_eff == '0) ? 1'b0 : rnd_r;
  end

  assign done   = (6'(p_eff) + 6'd1) >= {1'b0, nb};
  assign last   = ch_eff >= (nch - 16'd1);
  assign accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !q_full;
  assign q_push      = accept && done;
  assign q_data.acc  = acc_nxt;
  assign q_data.rnd  = rnd_nxt;
  assign q_data.chan = ch_eff;
  assign q_data.last = last;

  always_comb begin
    if (done) begin
      pos_nxt = '0;
      ch_nxt  = last ? 16'd0 : ch_eff + 16'd1;
    end else begin
      pos_nxt = PW'(6'(p_eff) + 6'd1);
      ch_nxt  = ch_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ch_r  <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      ch_r  <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= acc_nxt;
      rnd_r <= rnd_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < MAX_BYTES)
    else $error("byte position beyond the largest container");
`endif

endmodule

// ===== rtl/psuc_fifo.sv =====
// Short queue of assembled samples between the front and back ends.
module psuc_fifo #(
  parameter int unsigned DEPTH = psuc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psuc_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output psuc_pkg::q_entry_t pop_data,
  output logic               empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  psuc_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      cnt_r;
  logic               do_push, do_pop;

  assign full     = cnt_r == CW'(DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= DEPTH)
    else $error("queue fill count beyond its depth");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue fill count missed a transfer");
`endif

endmodule

// ===== rtl/psuc_back.sv =====
// Back end: one-byte sign flip, rounding and valid-bit masking, then output format conversion.
module psuc_back #(
  parameter int unsigned MAX_BYTES = psuc_pkg::MAX_BYTES_PER_SAMPLE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psuc_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  psuc_pkg::q_entry_t q_data,
  output logic               q_pop,
  psuc_out_if.source         out_ch
);

  logic [4:0]  nb;
  logic [7:0]  nb8;
  logic [6:0]  kk;
  logic [5:0]  shamt;
  logic [63:0] v0, v1, mask;
  logic        one_byte, wide;

  logic        a_valid_r, a_ready, b_ready;
  logic [63:0] a_val_r;
  logic [15:0] a_chan_r;
  logic        a_last_r;

  logic [7:0]         t8;
  logic [15:0]        t16;
  logic [31:0]        t32;
  logic signed [31:0] conv;

  logic               o_valid_r;
  logic signed [31:0] o_val_r;
  logic [15:0]        o_chan_r;
  logic               o_last_r;

  assign nb       = psuc_pkg::eff_bytes(cfg.bytes_per_sample, 5'(MAX_BYTES));
  assign nb8      = {nb, 3'b000};
  assign one_byte = nb == 5'd1;
  assign wide     = nb > 5'd8;

  always_comb begin
    v0 = q_data.acc ^ {one_byte, 63'd0};
    if (wide && q_data.rnd && v0 != 64'h7FFF_FFFF_FFFF_FFFF) v1 = v0 + 64'd1;
    else                                                     v1 = v0;
    kk = cfg.valid_bits;
    if ({1'b0, kk} > nb8) kk = nb8[6:0];
    if (kk > 7'd64) kk = 7'd64;
    if (kk == 7'd0) kk = 7'd1;
    shamt = 6'(7'd64 - kk);
    mask  = ~64'd0 << shamt;
  end

  assign b_ready = !o_valid_r || out_ch.ready;
  assign a_ready = !a_valid_r || b_ready;
  assign q_pop   = !q_empty && a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_val_r  <= v1 & mask;
      a_chan_r <= q_data.chan;
      a_last_r <= q_data.last;
    end
  end

  always_comb begin
    t8  = a_val_r[63:56] ^ 8'h80;
    t16 = a_val_r[63:48];
    t32 = a_val_r[63:32];
    if (a_val_r[55] && t8 != 8'hFF)            t8  = t8 + 8'd1;
    if (a_val_r[47] && t16 != 16'h7FFF)        t16 = t16 + 16'd1;
    if (a_val_r[31] && t32 != 32'h7FFF_FFFF)   t32 = t32 + 32'd1;
    case (cfg.output_format)
      psuc_pkg::FMT_U8:  conv = $signed({24'd0, t8});
      psuc_pkg::FMT_S16: conv = $signed({{16{t16[15]}}, t16});
      default:           conv = $signed(t32);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (b_ready) begin
      o_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      o_val_r  <= conv;
      o_chan_r <= a_chan_r;
      o_last_r <= a_last_r;
    end
  end

  assign out_ch.valid         = o_valid_r;
  assign out_ch.sample_value  = o_val_r;
  assign out_ch.channel_index = o_chan_r;
  assign out_ch.end_of_block  = o_last_r;

`ifndef SYNTHESIS
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_ready |=> a_valid_r && $stable(a_val_r))
    else $error("masking stage lost a sample while the output was stalled");
`endif

endmodule

// ===== rtl/pcm_sample_unpack_convert.sv =====
// Top level of the PCM sample unpacker and format converter.
//
//   Channel   Direction  Handshake              Payload
//   in_ch     input      valid/ready            data_byte, chunk_start
//   out_ch    output     valid/ready            sample_value, channel_index, end_of_block
//   cfg_*     input      APB write, pready = 1  four 32-bit registers at 4*index
//
// One byte is taken per cycle while the sample queue has room; a completed sample
// passes through front assembly, the queue, the mask stage and the convert stage.
// The front stalls only when the sample queue is full, which happens after the output
// is held back for long enough. Reset is synchronous and active low and returns the
// registers to their defaults and the byte and channel positions to zero.
module pcm_sample_unpack_convert #(
  parameter int unsigned MAX_BYTES   = psuc_pkg::MAX_BYTES_PER_SAMPLE,
  parameter int unsigned QUEUE_DEPTH = psuc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  psuc_in_if.sink                          in_ch,
  psuc_out_if.source                       out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [psuc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [psuc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [psuc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  psuc_pkg::cfg_t     cfg;
  psuc_pkg::q_entry_t push_data, pop_data;
  logic               q_push, q_pop, q_full, q_empty;

  psuc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  psuc_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  psuc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  psuc_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/sv/pcm_sample_unpack_convert_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each converted PCM sample and compares it with the block's output.
module pcm_sample_unpack_convert_checker
  import psuc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  psuc_in_if                    in_mon,
  psuc_out_if                   out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    errors,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    logic [31:0] sample;
    logic [15:0] chan;
    logic        eob;
  } sample_rec_t;

  logic [4:0]  bps_r;
  logic [6:0]  vbits_r;
  logic [15:0] chans_r;
  fmt_t        fmt_r;

  logic [63:0] acc;
  logic [3:0]  bpos;
  logic        rnd;
  logic [15:0] chpos;

  sample_rec_t expected_samples[$];

  function automatic bit unpack_byte(input logic [7:0] b, input logic cs,
                                     output sample_rec_t rec);
    int          nb;
    int          p;
    int          sh;
    int          k;
    int unsigned nch;
    logic [63:0] v;
    logic [63:0] mask;
    logic [31:0] t;
    logic        last;
    rec = '0;
    nb = bps_r;
    if (nb == 0) nb = 1;
    if (nb > MAX_BYTES_PER_SAMPLE) nb = MAX_BYTES_PER_SAMPLE;
    nch = (chans_r == 16'd0) ? 1 : chans_r;
    if (cs) begin
      bpos = '0;
      chpos = '0;
    end
    p = bpos;
    if (p == 0) begin
      acc = '0;
      rnd = 1'b0;
    end
    if (nb <= 8) begin
      sh = 64 - 8 * nb + 8 * p;
      if (sh < 64) acc |= {56'd0, b} << sh;
    end else if (p >= nb - 8) begin
      sh = 8 * (p - (nb - 8));
      if (sh < 64) acc |= {56'd0, b} << sh;
    end else if (p == nb - 9) begin
      rnd = b[7];
    end
    if (p + 1 < nb) begin
      bpos = 4'(p + 1);
      return 1'b0;
    end

    // The sample is complete: flip, round, mask and convert.
    v = acc;
    if (nb == 1) v[63] = ~v[63];
    if (nb > 8 && rnd && v != 64'h7FFF_FFFF_FFFF_FFFF) v = v + 64'd1;
    k = vbits_r;
    if (k > 8 * nb) k = 8 * nb;
    if (k > 64) k = 64;
    if (k == 0) k = 1;
    mask = {64{1'b1}} << (64 - k);
    v &= mask;
    last = (chpos >= nch - 1);
    t = '0;
    case (fmt_r)
      FMT_U8: begin
        t[7:0] = v[63:56] ^ 8'h80;
        if (v[55] && t[7:0] != 8'hFF) t[7:0] = t[7:0] + 8'd1;
      end
      FMT_S16: begin
        t[15:0] = v[63:48];
        if (v[47] && t[15:0] != 16'h7FFF) t[15:0] = t[15:0] + 16'd1;
        t[31:16] = {16{t[15]}};
      end
      default: begin
        t = v[63:32];
        if (v[31] && t != 32'h7FFF_FFFF) t = t + 32'd1;
      end
    endcase
    rec.sample = t;
    rec.chan = chpos;
    rec.eob = last;
    chpos = last ? 16'd0 : chpos + 16'd1;
    bpos = '0;
    acc = '0;
    rnd = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    sample_rec_t rec;
    sample_rec_t got;
    if (!rst_n) begin
      bps_r = BPS_RESET;
      vbits_r = VBITS_RESET;
      chans_r = CHANS_RESET;
      fmt_r = FMT_S16;
      acc = '0;
      bpos = '0;
      rnd = 1'b0;
      chpos = '0;
      expected_samples.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_BYTES_PER_SAMPLE: bps_r = cfg_pwdata[4:0];
          REG_VALID_BITS:       vbits_r = cfg_pwdata[6:0];
          REG_CHANNEL_COUNT:    chans_r = cfg_pwdata[15:0];
          REG_OUTPUT_FORMAT:    fmt_r = fmt_t'(cfg_pwdata[1:0]);
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.sample = out_mon.sample_value;
        got.chan = out_mon.channel_index;
        got.eob = out_mon.end_of_block;
        if (expected_samples.size() == 0) begin
          errors++;
          $error("sample transfer with no expectation: value %0h, channel %0d",
                 got.sample, got.chan);
        end else begin
          rec = expected_samples.pop_front();
          checked++;
          if (got.sample !== rec.sample) begin
            errors++;
            $error("sample_value: expected %0h, actual %0h", rec.sample, got.sample);
          end
          if (got.chan !== rec.chan) begin
            errors++;
            $error("channel_index: expected %0d, actual %0d", rec.chan, got.chan);
          end
          if (got.eob !== rec.eob) begin
            errors++;
            $error("end_of_block: expected %0b, actual %0b", rec.eob, got.eob);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (unpack_byte(in_mon.data_byte, in_mon.chunk_start, rec))
          expected_samples.push_back(rec);
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== tb/sv/pcm_sample_unpack_convert_test.sv =====
`timescale 1ns / 1ps
// Top of the PCM sample unpacker testbench: clock, reset, stimulus, watchdog and verdict.
module pcm_sample_unpack_convert_test;
  import psuc_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int errors;
  int pending;
  int checked;
  int bytes_sent = 0;
  int settings = 0;
  int quiet_cycles = 0;

  psuc_in_if  in_ch ();
  psuc_out_if out_ch ();

  pcm_sample_unpack_convert uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pcm_sample_unpack_convert_checker sample_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pcm_sample_unpack_convert verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic cs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.chunk_start <= cs;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic configure(input int bps, input int vb, input int ch, input fmt_t fmt);
    settle();
    cfg_write(REG_BYTES_PER_SAMPLE, 32'(bps));
    cfg_write(REG_VALID_BITS, 32'(vb));
    cfg_write(REG_CHANNEL_COUNT, 32'(ch));
    cfg_write(REG_OUTPUT_FORMAT, 32'(fmt));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    int          r;
    int          bps_pick;
    int          vb_pick;
    int          ch_pick;
    logic [7:0]  b;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.chunk_start <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: signed 16-bit extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);

    // Unsigned bytes, then a channel count that drops below the current position.
    configure(1, 64, 4, FMT_U8);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    configure(1, 64, 0, FMT_U8);
    send_byte(8'h5A, 1'b0);

    // Zero container size, zero valid bits and the unused format code.
    configure(0, 0, 1, FMT_RSV);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7F, 1'b0);

    // Oversized container, then a container shrunk in the middle of a sample.
    configure(31, 64, 2, FMT_S32);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    configure(2, 16, 2, FMT_S16);
    send_byte(8'h44, 1'b0);

    // Nine-byte container that rounds into the 64-bit maximum and saturates.
    configure(9, 64, 1, FMT_S32);
    send_byte(8'h80, 1'b1);
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        r = $urandom_range(99);
        if (r < 55) bps_pick = $urandom_range(1, 4);
        else if (r < 80) bps_pick = $urandom_range(5, 8);
        else if (r < 92) bps_pick = $urandom_range(9, 16);
        else bps_pick = ($urandom_range(1) == 0) ? 0 : $urandom_range(17, 31);
        if (seg == 3) bps_pick = (phase % 2 == 0) ? 16 : 1;
        vb_pick = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        r = $urandom_range(99);
        if (r < 70) ch_pick = $urandom_range(1, 4);
        else if (r < 85) ch_pick = $urandom_range(5, 16);
        else if (r < 93) ch_pick = 65535;
        else ch_pick = 0;
        configure(bps_pick, vb_pick, ch_pick, fmt_t'($urandom_range(3)));
        for (int n = 0; n < 25; n++) begin
          case ($urandom_range(9))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = ($urandom_range(1) == 0) ? 8'h7F : 8'h80;
            default: b = 8'($urandom_range(255));
          endcase
          send_byte(b, $urandom_range(99) < 3);
        end
      end
    end
    settle();

    $display("Run covered %0d bytes under %0d register settings and four pressure phases.",
             bytes_sent, settings);
    $display("%0d converted samples were compared field by field.", checked);
    if (errors == 0 && pending == 0) begin
      $display("pcm_sample_unpack_convert verification clean");
    end else begin
      $display("pcm_sample_unpack_convert verification failed");
    end
    $finish;
  end

endmodule
